// ===== rtl/sliding_window_sender_unit_defines.svh =====
// Assertion helpers shared by the sender unit RTL.
`ifndef SLIDING_WINDOW_SENDER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define SWSU_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("swsu: invariant violated");

// Same-cycle implication.
`define SWSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swsu: implication violated");

// Next-cycle implication.
`define SWSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swsu: next-cycle implication violated");

`endif

// ===== rtl/swsu_pkg.sv =====
package swsu_pkg;

    // Sequence counters carry one bit beyond the 32-bit fragment number
    localparam int SEQ_W          = 33;
    // Per-fragment ring: fragment f lives at entry f mod RING_DEPTH
    localparam int RING_AW        = 6;
    localparam int RING_DEPTH     = 1 << RING_AW;
    localparam int WINDOW_MAX_DEF = 32;
    localparam int TIME_WIDTH_DEF = 16;
    localparam int INITIAL_WINDOW = 10;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    // Input commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ACK  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_NEW    = 2'd0;
    localparam logic [1:0] KIND_RETX   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_TOTAL    = 2'd0;
    localparam logic [1:0] REG_INIT_ACK = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLIDE_RD,
        ST_SLIDE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_SEND,
        ST_STATUS
    } t_state;

    typedef struct packed {
        logic        cmd;
        logic [31:0] ack_number;
        logic [31:0] peer_sequence;
        logic [15:0] peer_window_size;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] fragment_number;
        logic [31:0] echo_ack;
        logic        more_flag;
        logic [7:0]  fragment_offset;
        logic        fragmented;
        logic [31:0] base_now;
        logic        done_res;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] total_fragments;
        logic [31:0] initial_ack_number;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // Access bundle for the acked-mark memory
    typedef struct packed {
        logic               rd_en;
        logic [RING_AW-1:0] rd_addr;
        logic               wr_en;
        logic [RING_AW-1:0] wr_addr;
        logic               wr_mark;
    } t_mark_req;

endpackage

// ===== rtl/swsu_mark_mem.sv =====
module swsu_mark_mem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swsu_pkg::t_mark_req  i_req,
    output logic                 o_mark
);

    logic                                r_mem [swsu_pkg::RING_DEPTH];
    logic [swsu_pkg::RING_DEPTH-1:0]     r_valid;
    logic                                r_rd_mark;
    logic                                r_rd_valid;

    // Mark storage, read data registered
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_mark;
        end
        if (i_req.rd_en) begin
            r_rd_mark <= r_mem[i_req.rd_addr];
        end
    end

    // Per-entry written flags; an unwritten entry reads as not acked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_mark = r_rd_mark & r_rd_valid;

endmodule

// ===== rtl/swsu_stamp_mem.sv =====
module swsu_stamp_mem #(
    parameter int DATA_W = swsu_pkg::TIME_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [swsu_pkg::RING_AW-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [swsu_pkg::RING_AW-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]            i_wr_data,
    output logic [DATA_W-1:0]            o_rd_data
);

    logic [DATA_W-1:0] r_mem [swsu_pkg::RING_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Send-time stamps, one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/swsu_cfg.sv =====
module swsu_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swsu_pkg::PADDR_W-1:0] paddr,
    input  logic [swsu_pkg::PDATA_W-1:0] pwdata,
    output logic [swsu_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output swsu_pkg::t_cfg               o_cfg
);

    logic [31:0] r_total;
    logic [31:0] r_init_ack;
    logic [15:0] r_timeout;
    logic [1:0]  reg_idx;
    logic        wr_fire;

    assign reg_idx = paddr[swsu_pkg::PADDR_W-1:2];
    assign wr_fire = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= 32'd1;
            r_init_ack <= 32'd0;
            r_timeout  <= 16'd1;
        end else if (wr_fire) begin
            case (reg_idx)
                swsu_pkg::REG_TOTAL:    r_total    <= pwdata;
                swsu_pkg::REG_INIT_ACK: r_init_ack <= pwdata;
                swsu_pkg::REG_TIMEOUT:  r_timeout  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            swsu_pkg::REG_TOTAL:    prdata = r_total;
            swsu_pkg::REG_INIT_ACK: prdata = r_init_ack;
            swsu_pkg::REG_TIMEOUT:  prdata = {16'd0, r_timeout};
            default:                prdata = '0;
        endcase
    end

    assign o_cfg.total_fragments    = r_total;
    assign o_cfg.initial_ack_number = r_init_ack;
    assign o_cfg.timeout_ticks      = r_timeout;

endmodule

// ===== rtl/sliding_window_sender_unit.sv =====
// Channel  | Valid        | Stall        | Payload      | Direction
// ---------+--------------+--------------+--------------+----------
// in       | i_in_valid   | o_in_stall   | i_in_data    | tick or ack into the unit
// out      | o_out_valid  | i_out_stall  | o_out_data   | send commands, then status
// cfg      | psel/penable | pready (1)   | paddr/pwdata | register writes and reads
//
// The input stalls from an accepted item until the unit is idle again: the slide (S),
// the timeout scan (F scanned), the new sends (N) and the status; S and F + N each
// stay within WINDOW_MAX. The single mark-memory read port, visited one entry per
// cycle in the slide and, while no due entry waits for output, in the timeout scan,
// sets the pace. i_out_stall against a pending result holds the unit back.
// Reset is synchronous; mark entries carry written flags, so no clearing pass.
`include "sliding_window_sender_unit_defines.svh"

module sliding_window_sender_unit #(
    parameter int WINDOW_MAX = swsu_pkg::WINDOW_MAX_DEF,
    parameter int TIME_WIDTH = swsu_pkg::TIME_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  swsu_pkg::t_in_item           i_in_data,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output swsu_pkg::t_out_item          o_out_data,
    input  logic                         i_out_stall,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swsu_pkg::PADDR_W-1:0] paddr,
    input  logic [swsu_pkg::PDATA_W-1:0] pwdata,
    output logic [swsu_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int SEQ_W   = swsu_pkg::SEQ_W;
    localparam int AW      = swsu_pkg::RING_AW;
    localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
    localparam int INIT_WIN = (swsu_pkg::INITIAL_WINDOW < WINDOW_MAX) ?
                              swsu_pkg::INITIAL_WINDOW : WINDOW_MAX;
    localparam logic [WIN_W-1:0] WIN_MAX_V  = WIN_W'(WINDOW_MAX);
    localparam logic [WIN_W-1:0] WIN_INIT_V = WIN_W'(INIT_WIN);
    localparam logic [15:0]      WIN_MAX_16 = 16'(WINDOW_MAX);
    localparam logic [SEQ_W-1:0] IN_FLIGHT_MAX = SEQ_W'(WINDOW_MAX);

    swsu_pkg::t_state    r_state, n_state;
    logic [SEQ_W-1:0]    r_base, n_base;
    logic [SEQ_W-1:0]    r_nts, n_nts;
    logic [SEQ_W-1:0]    r_idx, n_idx;
    logic [WIN_W-1:0]    r_n, n_n;
    logic [WIN_W-1:0]    r_allowed;
    logic [31:0]         r_echo;
    logic                r_echo_vld;
    logic [TIME_WIDTH-1:0] r_tick;
    logic                r_out_valid;
    swsu_pkg::t_out_item r_out_data, out_pl;

    swsu_pkg::t_cfg      cfg;
    swsu_pkg::t_mark_req mark_req;
    logic                mark_q;
    logic                st_rd_en, st_wr_en;
    logic [AW-1:0]       st_rd_addr, st_wr_addr;
    logic [TIME_WIDTH-1:0] stamp_q, age;

    logic                in_accept, ack_hit, out_free, due, emit, is_send;
    logic [1:0]          emit_kind;
    logic [SEQ_W-1:0]    emit_frag, total33, ack33, base_inc, idx_next, nts_inc;
    logic [WIN_W-1:0]    n_inc, n_after, win_clamped;
    logic                base_le_total, base_lt_nts, send_ok;

    swsu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    swsu_mark_mem u_mark_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mark_req),
        .o_mark  (mark_q)
    );

    swsu_stamp_mem #(
        .DATA_W (TIME_WIDTH)
    ) u_stamp_mem (
        .i_clk     (i_clk),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (r_tick),
        .o_rd_data (stamp_q)
    );

    // Shared compares and increments
    assign total33       = {1'b0, cfg.total_fragments};
    assign ack33         = {1'b0, i_in_data.ack_number};
    assign base_inc      = r_base + 1'b1;
    assign idx_next      = r_idx + 1'b1;
    assign nts_inc       = r_nts + 1'b1;
    assign n_inc         = r_n + 1'b1;
    assign base_le_total = (r_base <= total33);
    assign base_lt_nts   = (r_base < r_nts);
    assign send_ok       = (r_nts < (r_base + SEQ_W'(r_allowed))) && (r_nts <= total33) &&
                           (r_n < WIN_MAX_V);

    assign in_accept = i_in_valid && (r_state == swsu_pkg::ST_IDLE);
    assign ack_hit   = in_accept && (i_in_data.cmd == swsu_pkg::CMD_ACK) &&
                       (ack33 >= r_base) && (ack33 < r_nts);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Timer expiry for the entry under scan
    assign age = r_tick - stamp_q;
    assign due = !mark_q && (32'(age) >= 32'(cfg.timeout_ticks));
    assign n_after = due ? n_inc : r_n;

    // Peer window: zero becomes one, saturate at the window limit
    always_comb begin
        if (i_in_data.peer_window_size == 16'd0) begin
            win_clamped = WIN_W'(1);
        end else if (i_in_data.peer_window_size > WIN_MAX_16) begin
            win_clamped = WIN_MAX_V;
        end else begin
            win_clamped = i_in_data.peer_window_size[WIN_W-1:0];
        end
    end

    // Sequencer: slide, timeout scan, new sends, status
    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_nts      = r_nts;
        n_idx      = r_idx;
        n_n        = r_n;
        mark_req   = '0;
        st_rd_en   = 1'b0;
        st_rd_addr = r_idx[AW-1:0];
        st_wr_en   = 1'b0;
        st_wr_addr = r_idx[AW-1:0];
        emit       = 1'b0;
        emit_kind  = swsu_pkg::KIND_STATUS;
        emit_frag  = '0;
        case (r_state)
            swsu_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = swsu_pkg::ST_SLIDE_RD;
                    n_n     = '0;
                end
                if (ack_hit) begin
                    mark_req.wr_en   = 1'b1;
                    mark_req.wr_addr = i_in_data.ack_number[AW-1:0];
                    mark_req.wr_mark = 1'b1;
                end
            end
            swsu_pkg::ST_SLIDE_RD: begin
                mark_req.rd_en   = 1'b1;
                mark_req.rd_addr = r_base[AW-1:0];
                n_state          = swsu_pkg::ST_SLIDE;
            end
            swsu_pkg::ST_SLIDE: begin
                if (base_le_total && base_lt_nts && mark_q) begin
                    n_base           = base_inc;
                    mark_req.rd_en   = 1'b1;
                    mark_req.rd_addr = base_inc[AW-1:0];
                end else if (base_le_total) begin
                    n_idx   = r_base;
                    n_state = swsu_pkg::ST_SCAN_RD;
                end else begin
                    n_state = swsu_pkg::ST_STATUS;
                end
            end
            swsu_pkg::ST_SCAN_RD: begin
                if ((r_idx < r_nts) && (r_n < WIN_MAX_V)) begin
                    mark_req.rd_en   = 1'b1;
                    mark_req.rd_addr = r_idx[AW-1:0];
                    st_rd_en         = 1'b1;
                    n_state          = swsu_pkg::ST_SCAN;
                end else begin
                    n_state = swsu_pkg::ST_SEND;
                end
            end
            swsu_pkg::ST_SCAN: begin
                // a due entry waits for the output register; data is held
                if (due && out_free) begin
                    emit      = 1'b1;
                    emit_kind = swsu_pkg::KIND_RETX;
                    emit_frag = r_idx;
                    st_wr_en  = 1'b1;
                    n_n       = n_inc;
                end
                if (!due || out_free) begin
                    n_idx = idx_next;
                    if ((idx_next < r_nts) && (n_after < WIN_MAX_V)) begin
                        mark_req.rd_en   = 1'b1;
                        mark_req.rd_addr = idx_next[AW-1:0];
                        st_rd_en         = 1'b1;
                        st_rd_addr       = idx_next[AW-1:0];
                    end else begin
                        n_state = swsu_pkg::ST_SEND;
                    end
                end
            end
            swsu_pkg::ST_SEND: begin
                if (send_ok) begin
                    if (out_free) begin
                        emit             = 1'b1;
                        emit_kind        = swsu_pkg::KIND_NEW;
                        emit_frag        = r_nts;
                        st_wr_en         = 1'b1;
                        st_wr_addr       = r_nts[AW-1:0];
                        mark_req.wr_en   = 1'b1;
                        mark_req.wr_addr = r_nts[AW-1:0];
                        mark_req.wr_mark = 1'b0;
                        n_nts            = nts_inc;
                        n_n              = n_inc;
                    end
                end else begin
                    n_state = swsu_pkg::ST_STATUS;
                end
            end
            swsu_pkg::ST_STATUS: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = swsu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swsu_pkg::ST_IDLE;
            end
        endcase
    end

    // Result item assembly
    always_comb begin
        is_send                = (emit_kind != swsu_pkg::KIND_STATUS);
        out_pl.kind            = emit_kind;
        out_pl.fragment_number = is_send ? emit_frag[31:0] : 32'd0;
        out_pl.echo_ack        = r_echo_vld ? r_echo : cfg.initial_ack_number;
        out_pl.more_flag       = is_send && (emit_frag != total33);
        out_pl.fragment_offset = is_send ? (emit_frag[7:0] - 8'd1) : 8'd0;
        out_pl.fragmented      = is_send && (cfg.total_fragments > 32'd1);
        out_pl.base_now        = r_base[31:0];
        out_pl.done_res        = (r_base > total33);
        out_pl.last            = !is_send;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swsu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window state, echo and tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= SEQ_W'(1);
            r_nts      <= SEQ_W'(1);
            r_n        <= '0;
            r_allowed  <= WIN_INIT_V;
            r_echo     <= 32'd0;
            r_echo_vld <= 1'b0;
            r_tick     <= '0;
        end else begin
            r_base <= n_base;
            r_nts  <= n_nts;
            r_n    <= n_n;
            if (in_accept && (i_in_data.cmd == swsu_pkg::CMD_TICK)) begin
                r_tick <= r_tick + 1'b1;
            end
            if (ack_hit) begin
                r_echo     <= i_in_data.peer_sequence;
                r_echo_vld <= 1'b1;
                r_allowed  <= win_clamped;
            end
        end
    end

    // Scan index
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= out_pl;
        end
    end

    assign o_in_stall  = (r_state != swsu_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    `SWSU_ASSERT_ALWAYS(a_base_not_past_nts, i_clk, i_rst_n, r_base <= r_nts)
    `SWSU_ASSERT_ALWAYS(a_in_flight_bound, i_clk, i_rst_n, (r_nts - r_base) <= IN_FLIGHT_MAX)
    `SWSU_ASSERT_IMPLIES(a_scan_in_flight, i_clk, i_rst_n, r_state == swsu_pkg::ST_SCAN, (r_idx >= r_base) && (r_idx < r_nts))
    `SWSU_ASSERT_NEXT(a_status_closes, i_clk, i_rst_n, (r_state == swsu_pkg::ST_STATUS) && out_free, (r_state == swsu_pkg::ST_IDLE) && r_out_valid && r_out_data.last)

endmodule

// ===== test/window_sender_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and register ports of the sender unit, keeps its
// own copy of the window state and checks every result transfer in order.
module window_sender_checker #(
    parameter int WINDOW_MAX = swsu_pkg::WINDOW_MAX_DEF,
    parameter int TIME_WIDTH = swsu_pkg::TIME_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  swsu_pkg::t_in_item           i_in_data,
    input  logic                         i_in_stall,
    input  logic                         i_out_valid,
    input  swsu_pkg::t_out_item          i_out_data,
    input  logic                         i_out_stall,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [swsu_pkg::PADDR_W-1:0] i_paddr,
    input  logic [swsu_pkg::PDATA_W-1:0] i_pwdata,
    input  logic [swsu_pkg::PDATA_W-1:0] i_prdata,
    input  logic                         i_pready,
    output int                           o_fail_count,
    output int                           o_pending
);
    import swsu_pkg::*;

    localparam int MAX_REPORTS = 200;

    // Register copies
    logic [31:0]           total_frags;
    logic [31:0]           init_echo;
    logic [15:0]           resend_after;

    // Window state
    logic [SEQ_W-1:0]      base_seq;
    logic [SEQ_W-1:0]      next_seq;
    logic [5:0]            send_window;
    logic [31:0]           peer_echo;
    logic                  peer_echo_ok;
    logic [TIME_WIDTH-1:0] tick_now;
    logic                  acked [RING_DEPTH];
    logic [TIME_WIDTH-1:0] stamp [RING_DEPTH];

    t_out_item             due_results [$];
    t_out_item             oldest_due;
    logic [31:0]           reg_want;
    logic                  reg_known;
    int                    failures = 0;

    task automatic note_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: %s expected %h got %h", $time, label, want, got);
        end
    endtask

    // One send command or the closing status, as seen from the current state
    function automatic t_out_item shape_result(input logic [1:0] kind,
                                               input logic [SEQ_W-1:0] frag);
        t_out_item r;
        logic      sending;
        sending           = (kind != KIND_STATUS);
        r.kind            = kind;
        r.fragment_number = sending ? frag[31:0] : 32'd0;
        r.echo_ack        = peer_echo_ok ? peer_echo : init_echo;
        r.more_flag       = sending && (frag != {1'b0, total_frags});
        r.fragment_offset = sending ? frag[7:0] - 8'd1 : 8'd0;
        r.fragmented      = sending && (total_frags > 32'd1);
        r.base_now        = base_seq[31:0];
        r.done_res        = (base_seq > {1'b0, total_frags});
        r.last            = !sending;
        return r;
    endfunction

    // Apply one tick or ack and queue the commands it causes
    task automatic advance_window(input t_in_item it);
        logic [SEQ_W-1:0]      ack;
        logic [SEQ_W-1:0]      total;
        logic [SEQ_W-1:0]      idx;
        logic [RING_AW-1:0]    slot;
        logic [TIME_WIDTH-1:0] age;
        logic [15:0]           pw;
        int                    made;
        ack   = {1'b0, it.ack_number};
        total = {1'b0, total_frags};
        made  = 0;

        if (it.cmd == CMD_TICK) begin
            tick_now = tick_now + 1'b1;
        end else if (ack >= base_seq && ack < next_seq) begin
            acked[ack[RING_AW-1:0]] = 1'b1;
            peer_echo    = it.peer_sequence;
            peer_echo_ok = 1'b1;
            pw = it.peer_window_size;
            if (pw == 16'd0) pw = 16'd1;
            if (pw > 16'(WINDOW_MAX)) pw = 16'(WINDOW_MAX);
            send_window = pw[5:0];
        end

        // slide past acked fragments
        while (base_seq <= total && base_seq < next_seq && acked[base_seq[RING_AW-1:0]])
            base_seq++;

        if (base_seq <= total) begin
            // resend expired fragments, lowest first
            for (idx = base_seq; idx < next_seq && made < WINDOW_MAX; idx++) begin
                slot = idx[RING_AW-1:0];
                age  = tick_now - stamp[slot];
                if (!acked[slot] && age >= resend_after) begin
                    due_results.push_back(shape_result(KIND_RETX, idx));
                    made++;
                    stamp[slot] = tick_now;
                end
            end
            // fill the window with new fragments
            while (next_seq < base_seq + send_window && next_seq <= total
                   && made < WINDOW_MAX) begin
                slot = next_seq[RING_AW-1:0];
                due_results.push_back(shape_result(KIND_NEW, next_seq));
                made++;
                stamp[slot] = tick_now;
                acked[slot] = 1'b0;
                next_seq++;
            end
        end
        due_results.push_back(shape_result(KIND_STATUS, '0));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            total_frags  = 32'd1;
            init_echo    = 32'd0;
            resend_after = 16'd1;
            base_seq     = SEQ_W'(1);
            next_seq     = SEQ_W'(1);
            send_window  = 6'((INITIAL_WINDOW < WINDOW_MAX) ? INITIAL_WINDOW : WINDOW_MAX);
            peer_echo    = 32'd0;
            peer_echo_ok = 1'b0;
            tick_now     = '0;
            for (int k = 0; k < RING_DEPTH; k++) begin
                acked[k] = 1'b0;
                stamp[k] = '0;
            end
            due_results.delete();
        end else begin
            // register port
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        REG_TOTAL:    total_frags  = i_pwdata;
                        REG_INIT_ACK: init_echo    = i_pwdata;
                        REG_TIMEOUT:  resend_after = i_pwdata[15:0];
                        default: ;
                    endcase
                end else begin
                    reg_known = 1'b1;
                    case (i_paddr[3:2])
                        REG_TOTAL:    reg_want = total_frags;
                        REG_INIT_ACK: reg_want = init_echo;
                        REG_TIMEOUT:  reg_want = {16'd0, resend_after};
                        default:      reg_known = 1'b0;
                    endcase
                    if (reg_known) note_field("register read", reg_want, i_prdata);
                end
            end

            // result transfer
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: result expected none got %h", $time, i_out_data);
                end else begin
                    oldest_due = due_results.pop_front();
                    note_field("kind", oldest_due.kind, i_out_data.kind);
                    note_field("fragment_number", oldest_due.fragment_number,
                               i_out_data.fragment_number);
                    note_field("echo_ack", oldest_due.echo_ack, i_out_data.echo_ack);
                    note_field("more_flag", oldest_due.more_flag, i_out_data.more_flag);
                    note_field("fragment_offset", oldest_due.fragment_offset,
                               i_out_data.fragment_offset);
                    note_field("fragmented", oldest_due.fragmented, i_out_data.fragmented);
                    note_field("base_now", oldest_due.base_now, i_out_data.base_now);
                    note_field("done_res", oldest_due.done_res, i_out_data.done_res);
                    note_field("last", oldest_due.last, i_out_data.last);
                end
            end

            // item transfer
            if (i_in_valid && !i_in_stall) advance_window(i_in_data);
        end
        o_fail_count <= failures;
        o_pending    <= due_results.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import swsu_pkg::*;

    localparam int ITEM_TARGET  = 450;
    localparam int MAX_GAP      = 17;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 120;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    t_in_item           in_data     = '0;
    logic               in_stall;
    logic               out_valid;
    t_out_item          out_data;
    logic               out_stall   = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    // last base and highest new fragment seen on the result side
    logic [31:0]        seen_base   = 32'd1;
    logic [31:0]        seen_top    = 32'd0;
    logic               src_no_gaps = 1'b0;
    logic               snk_no_gaps = 1'b0;
    int                 items_sent  = 0;
    int                 idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    sliding_window_sender_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    window_sender_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_data    (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_data),
        .i_out_stall  (out_stall),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // track window progress for ack generation
    always @(posedge i_clk) begin
        if (out_valid && !out_stall) begin
            seen_base <= out_data.base_now;
            if (out_data.kind == KIND_NEW) seen_top <= out_data.fragment_number;
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, two long hold-offs to back up the unit
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        forever begin
            if (taken == 150 || taken == 1500) gap = LONG_HOLD;
            else gap = snk_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            taken++;
        end
    end

    function automatic t_in_item ack_item(input logic [31:0] num, input logic [31:0] pseq,
                                          input logic [15:0] win);
        t_in_item it;
        it.cmd              = CMD_ACK;
        it.ack_number       = num;
        it.peer_sequence    = pseq;
        it.peer_window_size = win;
        return it;
    endfunction

    function automatic t_in_item tick_item();
        t_in_item it;
        it.cmd              = CMD_TICK;
        it.ack_number       = $urandom;
        it.peer_sequence    = $urandom;
        it.peer_window_size = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // mostly ticks and acks inside the window, some stray acks
    function automatic t_in_item random_item();
        int unsigned pick;
        int unsigned span;
        logic [31:0] num;
        logic [15:0] win;
        pick = $urandom_range(0, 99);
        span = (seen_top >= seen_base) ? seen_top - seen_base + 1 : 1;
        win  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 34));
        if (pick < 35) return tick_item();
        if (pick < 60) begin
            num = seen_base + $urandom_range(0, 2);
        end else if (pick < 85) begin
            num = seen_base + $urandom_range(0, span);
        end else begin
            case ($urandom_range(0, 2))
                0:       num = $urandom;
                1:       num = seen_base - 1;
                default: num = seen_top + 1 + $urandom_range(0, 3);
            endcase
        end
        return ack_item(num, $urandom, win);
    endfunction

    // one item transfer, after a random gap
    task automatic offer(input t_in_item it);
        int gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // stop offering and wait until every expected result has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // register access: setup cycle, then access cycle
    task automatic reg_access(input logic write, input logic [1:0] idx,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          phase_len;
        logic [31:0] total_pick;
        logic [15:0] wait_pick;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values
        reg_access(1'b0, REG_TOTAL, 32'd0);
        reg_access(1'b0, REG_INIT_ACK, 32'd0);
        reg_access(1'b0, REG_TIMEOUT, 32'd0);

        // empty transfer with zero timeout: status only, handshake echo
        reg_access(1'b1, REG_INIT_ACK, 32'hFFFF_FFFF);
        reg_access(1'b1, REG_TIMEOUT, 32'd0);
        reg_access(1'b1, REG_TOTAL, 32'd0);
        offer(tick_item());
        offer(ack_item(32'd1, 32'h1234_5678, 16'd5));
        settle();

        // largest transfer; zero timeout resends everything each step
        reg_access(1'b1, REG_TOTAL, 32'hFFFF_FFFF);
        offer(tick_item());
        offer(tick_item());
        offer(ack_item(32'd0, $urandom, 16'd8));
        offer(ack_item(32'hFFFF_FFFF, $urandom, 16'd8));
        offer(ack_item(32'd11, $urandom, 16'd8));
        offer(ack_item(32'd1, 32'd0, 16'd0));
        offer(tick_item());
        offer(ack_item(32'd2, 32'hFFFF_FFFF, 16'hFFFF));
        settle();

        // longest timeout, window clamping, out-of-order acks
        reg_access(1'b1, REG_TIMEOUT, 32'h0000_FFFF);
        offer(tick_item());
        offer(ack_item(32'd5, 32'hAAAA_AAAA, 16'd33));
        offer(ack_item(32'd3, 32'h5555_5555, 16'd32));
        offer(ack_item(32'd4, $urandom, 16'd1));
        settle();

        // shrink the transfer below what is in flight, then finish it
        reg_access(1'b1, REG_TOTAL, 32'd8);
        reg_access(1'b1, REG_TIMEOUT, 32'd1);
        offer(tick_item());
        offer(ack_item(32'd6, $urandom, 16'd4));
        offer(ack_item(32'd7, $urandom, 16'd4));
        offer(ack_item(32'd8, $urandom, 16'd4));
        offer(ack_item(32'd9, $urandom, 16'd4));
        offer(tick_item());

        // random phases, each with its own settings
        while (items_sent < ITEM_TARGET) begin
            settle();
            total_pick = ($urandom_range(0, 5) == 0) ? $urandom
                                                     : seen_base - 1 + $urandom_range(0, 70);
            case ($urandom_range(0, 7))
                0:       wait_pick = 16'd0;
                1:       wait_pick = 16'd1;
                2:       wait_pick = 16'd2;
                3:       wait_pick = 16'd3;
                4:       wait_pick = 16'd5;
                5:       wait_pick = 16'd9;
                6:       wait_pick = 16'hFFFF;
                default: wait_pick = 16'($urandom_range(1, 40));
            endcase
            reg_access(1'b1, REG_TOTAL, total_pick);
            reg_access(1'b1, REG_TIMEOUT, {16'd0, wait_pick});
            if ($urandom_range(0, 2) == 0) reg_access(1'b1, REG_INIT_ACK, $urandom);
            reg_access(1'b0, REG_TOTAL, 32'd0);
            reg_access(1'b0, REG_TIMEOUT, 32'd0);
            src_no_gaps <= ($urandom_range(0, 3) == 0);
            snk_no_gaps <= ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) offer(random_item());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/swsu_pkg.sv
rtl/swsu_mark_mem.sv
rtl/swsu_stamp_mem.sv
rtl/swsu_cfg.sv
rtl/sliding_window_sender_unit.sv
test/window_sender_checker.sv
test/tb.sv
